// File: rtl/core/box_line_overlay_grid_assert.svh
// assertion macros for the box-line overlay grid
// used by the top level; needs nothing else
`ifndef BOX_LINE_OVERLAY_GRID_ASSERT_SVH
`define BOX_LINE_OVERLAY_GRID_ASSERT_SVH

// same-cycle implication
`define BOLG_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define BOLG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/bolg_pkg.sv
// shared types, field widths, mark bits and glyph decode for the overlay grid
// no dependencies
package bolg_pkg;

   localparam int OP_W       = 3;
   localparam int ROW_W      = 6;
   localparam int COL_W      = 7;
   localparam int GLYPH_W    = 4;
   localparam int MARK_W     = 6;
   localparam int HEIGHT_W   = 7;
   localparam int WIDTH_W    = 8;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 8;

   typedef logic [MARK_W-1:0]  mark_type;
   typedef logic [GLYPH_W-1:0] glyph_type;

   typedef enum logic [OP_W-1:0] {
      OP_READ  = 3'd0,
      OP_LINE  = 3'd1,
      OP_TEXT  = 3'd2,
      OP_COVER = 3'd3,
      OP_CLEAR = 3'd4
   } op_type;

   localparam logic [CSR_IDX_W-1:0] REG_GRID_HEIGHT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_GRID_WIDTH  = 1'd1;

   localparam mark_type C_LEFT  = 6'd1;
   localparam mark_type C_RIGHT = 6'd2;
   localparam mark_type C_UP    = 6'd4;
   localparam mark_type C_DOWN  = 6'd8;
   localparam mark_type M_TEXT  = 6'd16;
   localparam mark_type M_COVER = 6'd32;

   localparam glyph_type GLYPH_SPACE    = 4'd0;
   localparam glyph_type GLYPH_HORIZ    = 4'd1;
   localparam glyph_type GLYPH_VERT     = 4'd2;
   localparam glyph_type GLYPH_LEFT_UP  = 4'd3;
   localparam glyph_type GLYPH_RIGHT_UP = 4'd4;
   localparam glyph_type GLYPH_LEFT_DN  = 4'd5;
   localparam glyph_type GLYPH_RIGHT_DN = 4'd6;
   localparam glyph_type GLYPH_NO_RIGHT = 4'd7;
   localparam glyph_type GLYPH_NO_LEFT  = 4'd8;
   localparam glyph_type GLYPH_NO_UP    = 4'd9;
   localparam glyph_type GLYPH_NO_DOWN  = 4'd10;
   localparam glyph_type GLYPH_CROSS    = 4'd11;
   localparam glyph_type GLYPH_TEXT     = 4'd12;
   localparam glyph_type GLYPH_COVER    = 4'd13;

   // connection bits: [0] left, [1] right, [2] up, [3] down
   function automatic glyph_type decode_mark(input mark_type m);
      glyph_type g;
      if (m == M_TEXT) begin
         g = GLYPH_TEXT;
      end else if (m == M_COVER) begin
         g = GLYPH_COVER;
      end else begin
         case (m[3:0])
            4'b0001, 4'b0010, 4'b0011: g = GLYPH_HORIZ;
            4'b0100, 4'b1000, 4'b1100: g = GLYPH_VERT;
            4'b0101: g = GLYPH_LEFT_UP;
            4'b0110: g = GLYPH_RIGHT_UP;
            4'b1001: g = GLYPH_LEFT_DN;
            4'b1010: g = GLYPH_RIGHT_DN;
            4'b1101: g = GLYPH_NO_RIGHT;
            4'b1110: g = GLYPH_NO_LEFT;
            4'b1011: g = GLYPH_NO_UP;
            4'b0111: g = GLYPH_NO_DOWN;
            4'b1111: g = GLYPH_CROSS;
            default: g = GLYPH_SPACE;
         endcase
      end
      return g;
   endfunction

endpackage

// File: rtl/core/bolg_req_if.sv
// request channel of the overlay grid: valid, ready and the request fields
// depends on bolg_pkg
interface bolg_req_if;
   logic                          valid;
   logic                          ready;
   logic [bolg_pkg::OP_W-1:0]     operation;
   logic [bolg_pkg::ROW_W-1:0]    row_a;
   logic [bolg_pkg::COL_W-1:0]    col_a;
   logic [bolg_pkg::ROW_W-1:0]    row_b;
   logic [bolg_pkg::COL_W-1:0]    col_b;

   modport source (output valid, operation, row_a, col_a, row_b, col_b, input ready);
   modport sink   (input valid, operation, row_a, col_a, row_b, col_b, output ready);
endinterface

// File: rtl/core/bolg_rsp_if.sv
// response channel of the overlay grid: valid, ready, glyph and error
// depends on bolg_pkg
interface bolg_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [bolg_pkg::GLYPH_W-1:0]  glyph;
   logic                          error;

   modport source (output valid, glyph, error, input ready);
   modport sink   (input valid, glyph, error, output ready);
endinterface

// File: rtl/core/box_line_overlay_grid.sv
// channel   direction  contents
// req_bus   in         operation, row_a, col_a, row_b, col_b
// rsp_bus   out        glyph, error (one response per request; none for a line cut short by a csr write)
// csr_*     in         write enable, index, data (grid_height, grid_width)
//
// read: memory read, then decode; text, cover, clear, errors: response registered on acceptance
// line: one read-modify-write per cell over the single ram, then a final write-back
// reset, a clear request or any register write sweeps all MAX_ROWS * MAX_COLS
//   cells (8192 at defaults) of the ram one cell a cycle, with no request taken
// a response waits in an output register; a new request is taken once it is taken
// depends on bolg_pkg, bolg_req_if, bolg_rsp_if, bolg_ram and the assert header
`include "box_line_overlay_grid_assert.svh"

module box_line_overlay_grid #(
   parameter int MAX_ROWS = 64,
   parameter int MAX_COLS = 128
) (
   input  logic                              clock,
   input  logic                              reset,
   bolg_req_if.sink                          req_bus,
   bolg_rsp_if.source                        rsp_bus,
   input  logic                              csr_we,
   input  logic [bolg_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bolg_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   localparam int DEPTH  = MAX_ROWS * MAX_COLS;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CMP_W  = 11;
   localparam logic [CMP_W-1:0]  ROW_LIM   = CMP_W'(MAX_ROWS);
   localparam logic [CMP_W-1:0]  COL_LIM   = CMP_W'(MAX_COLS);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_LINE,
      ST_LAST,
      ST_CLEAR
   } state_type;

   typedef logic [bolg_pkg::COL_W-1:0] coord_type;

   state_type                        state_ff;
   logic [ADDR_W-1:0]                clr_ff;
   logic [bolg_pkg::HEIGHT_W-1:0]    grid_height_ff;
   logic [bolg_pkg::WIDTH_W-1:0]     grid_width_ff;
   logic                             rsp_valid_ff;
   bolg_pkg::glyph_type              glyph_ff;
   logic                             error_ff;
   logic                             vert_ff;
   logic [bolg_pkg::ROW_W-1:0]       row_ff;
   coord_type                        col_ff;
   coord_type                        k_ff;
   coord_type                        lo_ff;
   coord_type                        hi_ff;
   logic                             pend_valid_ff;
   logic [ADDR_W-1:0]                pend_addr_ff;
   bolg_pkg::mark_type               pend_bits_ff;

   logic                             accept;
   logic                             a_ok;
   logic                             b_ok;
   logic                             is_h;
   logic                             is_v;
   coord_type                        lo_in;
   coord_type                        hi_in;
   logic [ADDR_W-1:0]                walk_addr;
   bolg_pkg::mark_type               walk_bits;
   bolg_pkg::mark_type               fwd_bit;
   bolg_pkg::mark_type               back_bit;
   logic                             single;
   logic                             mem_we;
   logic [ADDR_W-1:0]                mem_waddr;
   bolg_pkg::mark_type               mem_wdata;
   logic [ADDR_W-1:0]                mem_raddr;
   bolg_pkg::mark_type               mem_rdata;

   function automatic logic cell_ok(input logic [bolg_pkg::ROW_W-1:0] r,
                                    input coord_type c,
                                    input logic [bolg_pkg::HEIGHT_W-1:0] h,
                                    input logic [bolg_pkg::WIDTH_W-1:0] w);
      return (CMP_W'(r) < CMP_W'(h)) && (CMP_W'(r) < ROW_LIM) &&
             (CMP_W'(c) < CMP_W'(w)) && (CMP_W'(c) < COL_LIM);
   endfunction

   function automatic logic [ADDR_W-1:0] cell_addr(input coord_type r, input coord_type c);
      return ADDR_W'(int'(r) * MAX_COLS + int'(c));
   endfunction

   assign req_bus.ready = (state_ff == ST_IDLE) && !csr_we &&
                          (!rsp_valid_ff || rsp_bus.ready);
   assign accept        = req_bus.valid && req_bus.ready;

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.glyph = glyph_ff;
   assign rsp_bus.error = error_ff;

   always_comb begin
      a_ok = cell_ok(req_bus.row_a, req_bus.col_a, grid_height_ff, grid_width_ff);
      b_ok = cell_ok(req_bus.row_b, req_bus.col_b, grid_height_ff, grid_width_ff);
      is_h = (req_bus.row_a == req_bus.row_b);
      is_v = (req_bus.col_a == req_bus.col_b);
      if (is_h) begin
         lo_in = (req_bus.col_a < req_bus.col_b) ? req_bus.col_a : req_bus.col_b;
         hi_in = (req_bus.col_a < req_bus.col_b) ? req_bus.col_b : req_bus.col_a;
      end else begin
         lo_in = (req_bus.row_a < req_bus.row_b) ? {1'b0, req_bus.row_a}
                                                 : {1'b0, req_bus.row_b};
         hi_in = (req_bus.row_a < req_bus.row_b) ? {1'b0, req_bus.row_b}
                                                 : {1'b0, req_bus.row_a};
      end
   end

   // a single point only occurs on a horizontal line and gets both bits
   always_comb begin
      single    = (lo_ff == hi_ff);
      fwd_bit   = vert_ff ? bolg_pkg::C_DOWN : bolg_pkg::C_RIGHT;
      back_bit  = vert_ff ? bolg_pkg::C_UP : bolg_pkg::C_LEFT;
      walk_bits = (((k_ff != hi_ff) || single) ? fwd_bit : '0) |
                  (((k_ff != lo_ff) || single) ? back_bit : '0);
      walk_addr = vert_ff ? cell_addr(k_ff, col_ff) : cell_addr({1'b0, row_ff}, k_ff);
   end

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = pend_addr_ff;
      mem_wdata = mem_rdata | pend_bits_ff;
      mem_raddr = (state_ff == ST_LINE) ? walk_addr
                                        : cell_addr({1'b0, req_bus.row_a}, req_bus.col_a);
      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '0;
         end
         ST_LINE, ST_LAST: begin
            mem_we = pend_valid_ff;
         end
         ST_IDLE: begin
            if (accept && a_ok && (req_bus.operation == bolg_pkg::OP_TEXT ||
                                   req_bus.operation == bolg_pkg::OP_COVER)) begin
               mem_we    = 1'b1;
               mem_waddr = cell_addr({1'b0, req_bus.row_a}, req_bus.col_a);
               mem_wdata = (req_bus.operation == bolg_pkg::OP_TEXT) ? bolg_pkg::M_TEXT
                                                                    : bolg_pkg::M_COVER;
            end
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   bolg_ram #(
      .WIDTH (bolg_pkg::MARK_W),
      .DEPTH (DEPTH)
   ) u_marks (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         clr_ff         <= '0;
         grid_height_ff <= 7'd64;
         grid_width_ff  <= 8'd128;
         rsp_valid_ff   <= 1'b0;
         pend_valid_ff  <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  case (req_bus.operation)
                     bolg_pkg::OP_READ: begin
                        if (a_ok) begin
                           state_ff <= ST_READ;
                        end else begin
                           rsp_valid_ff <= 1'b1;
                           glyph_ff     <= bolg_pkg::GLYPH_SPACE;
                           error_ff     <= 1'b1;
                        end
                     end
                     bolg_pkg::OP_LINE: begin
                        if (a_ok && b_ok && (is_h || is_v)) begin
                           state_ff      <= ST_LINE;
                           vert_ff       <= !is_h;
                           row_ff        <= req_bus.row_a;
                           col_ff        <= req_bus.col_a;
                           lo_ff         <= lo_in;
                           hi_ff         <= hi_in;
                           k_ff          <= lo_in;
                           pend_valid_ff <= 1'b0;
                        end else begin
                           rsp_valid_ff <= 1'b1;
                           glyph_ff     <= bolg_pkg::GLYPH_SPACE;
                           error_ff     <= 1'b1;
                        end
                     end
                     bolg_pkg::OP_TEXT, bolg_pkg::OP_COVER: begin
                        rsp_valid_ff <= 1'b1;
                        glyph_ff     <= bolg_pkg::GLYPH_SPACE;
                        error_ff     <= !a_ok;
                     end
                     bolg_pkg::OP_CLEAR: begin
                        state_ff     <= ST_CLEAR;
                        clr_ff       <= '0;
                        rsp_valid_ff <= 1'b1;
                        glyph_ff     <= bolg_pkg::GLYPH_SPACE;
                        error_ff     <= 1'b0;
                     end
                     default: begin
                        rsp_valid_ff <= 1'b1;
                        glyph_ff     <= bolg_pkg::GLYPH_SPACE;
                        error_ff     <= 1'b1;
                     end
                  endcase
               end
            end
            ST_READ: begin
               state_ff     <= ST_IDLE;
               rsp_valid_ff <= 1'b1;
               glyph_ff     <= bolg_pkg::decode_mark(mem_rdata);
               error_ff     <= 1'b0;
            end
            ST_LINE: begin
               // read this cell, write back the previous one
               pend_valid_ff <= 1'b1;
               pend_addr_ff  <= walk_addr;
               pend_bits_ff  <= walk_bits;
               if (k_ff == hi_ff) begin
                  state_ff <= ST_LAST;
               end else begin
                  k_ff <= k_ff + 7'd1;
               end
            end
            ST_LAST: begin
               state_ff      <= ST_IDLE;
               pend_valid_ff <= 1'b0;
               rsp_valid_ff  <= 1'b1;
               glyph_ff      <= bolg_pkg::GLYPH_SPACE;
               error_ff      <= 1'b0;
            end
            ST_CLEAR: begin
               clr_ff <= ADDR_W'(clr_ff + 1'b1);
               if (clr_ff == LAST_ADDR) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
         // a resize wipes the grid
         if (csr_we) begin
            case (csr_index)
               bolg_pkg::REG_GRID_HEIGHT: begin
                  grid_height_ff <= csr_wdata[bolg_pkg::HEIGHT_W-1:0];
                  state_ff       <= ST_CLEAR;
                  clr_ff         <= '0;
               end
               bolg_pkg::REG_GRID_WIDTH: begin
                  grid_width_ff <= csr_wdata;
                  state_ff      <= ST_CLEAR;
                  clr_ff        <= '0;
               end
               default: begin
                  state_ff <= state_ff;
               end
            endcase
         end
      end
   end

   `BOLG_ASSERT_NEXT(a_read_goes_to_decode, clock, reset,
      accept && a_ok && req_bus.operation == bolg_pkg::OP_READ, state_ff == ST_READ,
      "in-range read did not move to decode")
   `BOLG_ASSERT_NOW(a_walk_in_bounds, clock, reset,
      state_ff == ST_LINE, k_ff >= lo_ff && k_ff <= hi_ff,
      "line walk index left its segment")
   `BOLG_ASSERT_NOW(a_last_write_back, clock, reset,
      state_ff == ST_LAST, mem_we && pend_valid_ff,
      "final line cell not written back")
   `BOLG_ASSERT_NOW(a_no_take_while_blocked, clock, reset,
      rsp_valid_ff && !rsp_bus.ready, !accept,
      "request taken while the response register is stalled")
endmodule

// File: rtl/core/bolg_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module bolg_ram #(
   parameter int WIDTH = 6,
   parameter int DEPTH = 8192,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [ADDR_W-1:0]        waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [ADDR_W-1:0]        raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule
